// ----- rtl/core/kms_pkg.sv -----
// Shared types, keymap tables and lookup helpers for the keyboard matrix scanner.
`default_nettype none
package kms_pkg;

    localparam int MATRIX_ROWS = 8;
    localparam int MATRIX_COLS = 8;
    localparam int ROW_W       = $clog2(MATRIX_ROWS);
    localparam int COL_W       = $clog2(MATRIX_COLS);
    localparam int CODE_W      = 8;
    localparam int KEYS        = MATRIX_ROWS * MATRIX_COLS;
    localparam int OUT_DATA_W  = 16;

    // Modifier positions
    localparam logic [ROW_W-1:0] SHIFT_ROW  = ROW_W'(7);
    localparam logic [COL_W-1:0] SHIFT_COL  = COL_W'(0);
    localparam logic [ROW_W-1:0] FN_ROW     = ROW_W'(7);
    localparam logic [COL_W-1:0] FN_COL     = COL_W'(2);
    localparam logic [ROW_W-1:0] SYMBOL_ROW = ROW_W'(5);
    localparam logic [COL_W-1:0] SYMBOL_COL = COL_W'(3);
    localparam logic [COL_W-1:0] ALT_COL    = COL_W'(1);
    localparam logic [COL_W-1:0] CTRL_COL   = COL_W'(6);

    typedef enum logic [1:0] {
        KM_PLAIN,
        KM_SHIFT,
        KM_SYMBOL,
        KM_FN
    } t_keymap_sel;

    typedef logic [CODE_W-1:0] t_keymap [KEYS];

    // Index is row * 8 + col
    localparam t_keymap MAP_PLAIN = '{
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h00, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h09, 8'hE4, 8'h5C, 8'h27, 8'h2C, 8'h2E, 8'h2F, 8'hCE,
        8'h6F, 8'h6C, 8'h3D, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h6C,
        8'hC8, 8'h70, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam t_keymap MAP_SHIFT = '{
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h00, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h09, 8'hE4, 8'h7C, 8'h60, 8'h3B, 8'h3A, 8'h3F, 8'hCE,
        8'h4F, 8'h4C, 8'h2B, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h4C,
        8'hC8, 8'h50, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam t_keymap MAP_SYMBOL = '{
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h41, 8'h53, 8'h44, 8'h2D, 8'h5F, 8'h7B, 8'h5B, 8'h5D,
        8'h00, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h3C, 8'h3E,
        8'h09, 8'hE4, 8'h5C, 8'h60, 8'h27, 8'h22, 8'h2F, 8'hCE,
        8'h28, 8'h7D, 8'h3D, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h4C,
        8'hC8, 8'h29, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    localparam t_keymap MAP_FN = '{
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h37, 8'h38,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h34, 8'h35,
        8'h00, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h31, 8'h32,
        8'h09, 8'hE4, 8'h5C, 8'h27, 8'h2C, 8'h2E, 8'h30, 8'hCE,
        8'h39, 8'h36, 8'h33, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h6C,
        8'hC8, 8'h70, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // One decoded scan tick: new-press mask plus a code per row and the scanned column
    typedef struct packed {
        logic [MATRIX_ROWS-1:0]             mask;
        logic [MATRIX_ROWS-1:0][CODE_W-1:0] codes;
        logic [COL_W-1:0]                   col;
    } t_batch;

    function automatic logic [CODE_W-1:0] kms_lookup(
        input t_keymap_sel      sel,
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        logic [ROW_W+COL_W-1:0] idx;
        logic [CODE_W-1:0]      code;
        idx = {row, col};
        case (sel)
            KM_SHIFT:  code = MAP_SHIFT[idx];
            KM_SYMBOL: code = MAP_SYMBOL[idx];
            KM_FN:     code = MAP_FN[idx];
            default:   code = MAP_PLAIN[idx];
        endcase
        return code;
    endfunction

    function automatic logic kms_is_modifier(
        input logic [ROW_W-1:0] row,
        input logic [COL_W-1:0] col
    );
        return ((row == SHIFT_ROW) && ((col == SHIFT_COL) || (col == ALT_COL) ||
                                       (col == FN_COL))) ||
               ((row == SYMBOL_ROW) && ((col == SYMBOL_COL) || (col == CTRL_COL)));
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/kms_decode.sv -----
// Combinational decode of one scan tick into a new-press mask and per-row key codes.
`default_nettype none
module kms_decode
    import kms_pkg::*;
(
    input  wire logic [MATRIX_ROWS-1:0] i_levels,
    input  wire logic [MATRIX_ROWS-1:0] i_col_bits,
    input  wire logic [COL_W-1:0]       i_col,
    input  wire logic                   i_shift,
    input  wire logic                   i_symbol,
    input  wire logic                   i_fn,
    output t_batch                      o_batch,
    output logic [MATRIX_ROWS-1:0]      o_col_bits
);

    logic [MATRIX_ROWS-1:0] w_now;
    logic [MATRIX_ROWS-1:0] w_symbol;

    assign w_now      = ~i_levels;
    assign o_col_bits = w_now;

    always_comb begin
        o_batch.col = i_col;
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            // symbol key state updates mid-tick when its column is scanned
            if ((i_col == SYMBOL_COL) && (ROW_W'(r) > SYMBOL_ROW)) begin
                w_symbol[r] = w_now[SYMBOL_ROW];
            end else begin
                w_symbol[r] = i_symbol;
            end
            o_batch.mask[r] = w_now[r] & ~i_col_bits[r] &
                              ~kms_is_modifier(ROW_W'(r), i_col);
            if (i_shift) begin
                o_batch.codes[r] = kms_lookup(KM_SHIFT, ROW_W'(r), i_col);
            end else if (w_symbol[r]) begin
                o_batch.codes[r] = kms_lookup(KM_SYMBOL, ROW_W'(r), i_col);
            end else if (i_fn) begin
                o_batch.codes[r] = kms_lookup(KM_FN, ROW_W'(r), i_col);
            end else begin
                o_batch.codes[r] = kms_lookup(KM_PLAIN, ROW_W'(r), i_col);
            end
        end
    end

endmodule
`default_nettype wire

// ----- rtl/core/kms_serializer.sv -----
// Holds one decoded tick and sends its key codes out one beat per cycle while tready is high.
`default_nettype none
module kms_serializer
    import kms_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_load,
    input  wire t_batch                i_batch,
    output logic                       o_free,
    output logic                       o_tvalid,
    input  wire logic                  i_tready,
    output logic [OUT_DATA_W-1:0]      o_tdata,
    output logic                       o_tlast
);

    logic [MATRIX_ROWS-1:0]             r_mask;
    logic [MATRIX_ROWS-1:0]             n_mask;
    logic [MATRIX_ROWS-1:0][CODE_W-1:0] r_codes;
    logic [COL_W-1:0]                   r_col;
    logic [ROW_W-1:0]                   w_idx;
    logic [MATRIX_ROWS-1:0]             w_rest;
    logic                               w_take;

    always_comb begin
        w_idx = '0;
        for (int r = MATRIX_ROWS - 1; r >= 0; r--) begin
            if (r_mask[r]) begin
                w_idx = ROW_W'(r);
            end
        end
    end

    assign w_rest   = r_mask & (r_mask - MATRIX_ROWS'(1));
    assign o_tvalid = |r_mask;
    assign o_tlast  = ~|w_rest;
    assign w_take   = o_tvalid & i_tready;
    assign o_free   = ~o_tvalid | (w_take & o_tlast);
    assign o_tdata  = OUT_DATA_W'({r_col, w_idx, r_codes[w_idx]});

    always_comb begin
        if (i_load) begin
            n_mask = i_batch.mask;
        end else if (w_take) begin
            n_mask = w_rest;
        end else begin
            n_mask = r_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else begin
            r_mask <= n_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_codes <= i_batch.codes;
            r_col   <= i_batch.col;
        end
    end

`ifndef SYNTH
    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("tick loaded over pending beats");
    a_more_beats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !o_tlast) |=> o_tvalid)
        else $error("beats lost before tlast");
    a_count_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && !i_load) |=>
        ($countones(r_mask) == $past($countones(r_mask)) - 1))
        else $error("beat count did not drop by one");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/keyboard_matrix_scanner.sv -----
// Top level of the 8x8 keyboard matrix scanner: tick register, pressed map and output.
// Each input beat is one scan tick: the active-low row levels of the column being
// driven, with the column starting at 0 after reset and stepping by one per tick.
// A tick is registered, decoded against the pressed map in one pass and handed to
// the output stage, which sends one beat per newly pressed key in row order (at most
// eight, tlast on the final one); a tick with no new press sends nothing. Ticks are
// taken one per cycle while the output stage is free; a tick with new presses
// holds the output stage until its last beat is taken, at most one beat per cycle
// while tready is high, so the presses per tick set the sustained rate.
`default_nettype none
module keyboard_matrix_scanner
    import kms_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  wire logic [MATRIX_ROWS-1:0] i_s_axis_tdata,  // [7:0] row_levels
    output logic                        o_m_axis_tvalid,
    input  wire logic                   i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]       o_m_axis_tdata,  // [7:0] key_code, [10:8] key_row,
                                                         // [13:11] key_col, [15:14] zero
    output logic                        o_m_axis_tlast   // last
);

    logic                   r_in_vld;
    logic [MATRIX_ROWS-1:0] r_levels;
    logic [COL_W-1:0]       r_col;
    logic [MATRIX_ROWS-1:0] r_map [MATRIX_COLS];
    logic                   w_free;
    logic                   w_xfer;
    logic                   w_accept;
    t_batch                 w_batch;
    logic [MATRIX_ROWS-1:0] w_col_bits;

    assign w_xfer          = r_in_vld & w_free;
    assign o_s_axis_tready = ~r_in_vld | w_free;
    assign w_accept        = i_s_axis_tvalid & o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_col    <= '0;
            for (int c = 0; c < MATRIX_COLS; c++) begin
                r_map[c] <= '0;
            end
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_xfer) begin
                r_in_vld <= 1'b0;
            end
            if (w_xfer) begin
                r_map[r_col] <= w_col_bits;
                r_col        <= r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_levels <= i_s_axis_tdata;
        end
    end

    kms_decode u_decode (
        .i_levels   (r_levels),
        .i_col_bits (r_map[r_col]),
        .i_col      (r_col),
        .i_shift    (r_map[SHIFT_COL][SHIFT_ROW]),
        .i_symbol   (r_map[SYMBOL_COL][SYMBOL_ROW]),
        .i_fn       (r_map[FN_COL][FN_ROW]),
        .o_batch    (w_batch),
        .o_col_bits (w_col_bits)
    );

    kms_serializer u_serializer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_xfer),
        .i_batch  (w_batch),
        .o_free   (w_free),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tlast  (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

// ----- bench/keyboard_matrix_scanner_test.sv -----
// Self-checking bench for the keyboard scanner: scan ticks in, new-press key codes out.
`default_nettype none
module keyboard_matrix_scanner_test
    import kms_pkg::*;
();

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_TICKS  = 470;
    localparam int DRAIN_CYCLES  = 40;

    // Keymaps by row * 8 + col
    localparam logic [0:63][7:0] CODES_PLAIN = {
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B,
        8'h00, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h6E, 8'h6D,
        8'h09, 8'hE4, 8'h5C, 8'h27, 8'h2C, 8'h2E, 8'h2F, 8'hCE,
        8'h6F, 8'h6C, 8'h3D, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h6C,
        8'hC8, 8'h70, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [0:63][7:0] CODES_SHIFT = {
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
        8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B,
        8'h00, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h4E, 8'h4D,
        8'h09, 8'hE4, 8'h7C, 8'h60, 8'h3B, 8'h3A, 8'h3F, 8'hCE,
        8'h4F, 8'h4C, 8'h2B, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h4C,
        8'hC8, 8'h50, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [0:63][7:0] CODES_SYMBOL = {
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A,
        8'h41, 8'h53, 8'h44, 8'h2D, 8'h5F, 8'h7B, 8'h5B, 8'h5D,
        8'h00, 8'h5A, 8'h58, 8'h43, 8'h56, 8'h42, 8'h3C, 8'h3E,
        8'h09, 8'hE4, 8'h5C, 8'h60, 8'h27, 8'h22, 8'h2F, 8'hCE,
        8'h28, 8'h7D, 8'h3D, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h4C,
        8'hC8, 8'h29, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };
    localparam logic [0:63][7:0] CODES_FN = {
        8'hC1, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'h00,
        8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h37, 8'h38,
        8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68, 8'h34, 8'h35,
        8'h00, 8'h7A, 8'h78, 8'h63, 8'h76, 8'h62, 8'h31, 8'h32,
        8'h09, 8'hE4, 8'h5C, 8'h27, 8'h2C, 8'h2E, 8'h30, 8'hCE,
        8'h39, 8'h36, 8'h33, 8'h00, 8'h20, 8'h00, 8'hE2, 8'h6C,
        8'hC8, 8'h70, 8'h08, 8'h0A, 8'hCF, 8'hD0, 8'h80, 8'h80,
        8'hE0, 8'hE3, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct {
        logic [7:0]  levels;
        int unsigned gap;
    } scan_tick_t;

    typedef struct {
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              last;
    } key_press_t;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [MATRIX_ROWS-1:0] i_s_axis_tdata = '0;   // [7:0] row_levels
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;        // [7:0] code, [10:8] row, [13:11] col
    logic                   o_m_axis_tlast;

    scan_tick_t  scan_ticks[$];
    scan_tick_t  next_tick;
    key_press_t  pending_keys[$];
    key_press_t  got_key;
    key_press_t  want_key;

    logic [63:0]         key_map = '0;
    logic [COL_W-1:0]    scan_col = '0;
    logic                in_fire = 1'b0;
    int unsigned         hold_off = 0;
    int unsigned         stall_left = 0;
    int unsigned         cycle_count = 0;
    int unsigned         mismatch_count = 0;
    int unsigned         ticks_taken = 0;
    int unsigned         keys_checked = 0;
    int unsigned         map_hits[4] = '{0, 0, 0, 0};

    keyboard_matrix_scanner dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 25);
    endfunction

    // Every tick moves the column, so the key map and selection follow row order.
    task automatic decode_tick(input logic [7:0] levels);
        key_press_t  hits[8];
        int          n;
        logic [5:0]  pos;
        logic        now;
        logic        was;
        logic        is_mod;
        t_keymap_sel sel;
        n = 0;
        for (int r = 0; r < MATRIX_ROWS; r++) begin
            pos = {r[2:0], scan_col};
            now = ~levels[r];
            was = key_map[pos];
            key_map[pos] = now;
            is_mod = (r[2:0] == SHIFT_ROW && scan_col <= FN_COL) ||
                     (r[2:0] == SYMBOL_ROW && (scan_col == SYMBOL_COL ||
                                               scan_col == CTRL_COL));
            if (!is_mod && now && !was) begin
                if (key_map[{SHIFT_ROW, SHIFT_COL}])
                    sel = KM_SHIFT;
                else if (key_map[{SYMBOL_ROW, SYMBOL_COL}])
                    sel = KM_SYMBOL;
                else if (key_map[{FN_ROW, FN_COL}])
                    sel = KM_FN;
                else
                    sel = KM_PLAIN;
                case (sel)
                    KM_SHIFT:  hits[n].code = CODES_SHIFT[pos];
                    KM_SYMBOL: hits[n].code = CODES_SYMBOL[pos];
                    KM_FN:     hits[n].code = CODES_FN[pos];
                    default:   hits[n].code = CODES_PLAIN[pos];
                endcase
                hits[n].row = r[2:0];
                hits[n].col = scan_col;
                hits[n].last = 1'b0;
                map_hits[int'(sel)]++;
                n++;
            end
        end
        if (n > 0)
            hits[n-1].last = 1'b1;
        for (int k = 0; k < n; k++)
            pending_keys.push_back(hits[k]);
        scan_col = scan_col + 1'b1;
    endtask

    task automatic queue_tick(input logic [7:0] levels);
        scan_tick_t t;
        t.levels = levels;
        // every third block of 40 ticks runs back to back
        t.gap = ((scan_ticks.size() / 40) % 3 == 2) ? 0 : pick_gap();
        scan_ticks.push_back(t);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Some tests failed");
            $finish;
        end
    end

    // Check outgoing beats before decoding a tick taken at the same edge.
    always @(posedge i_clk) begin
        in_fire <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got_key.code = o_m_axis_tdata[7:0];
            got_key.row  = o_m_axis_tdata[10:8];
            got_key.col  = o_m_axis_tdata[13:11];
            got_key.last = o_m_axis_tlast;
            if (pending_keys.size() == 0) begin
                report_mismatch($sformatf("unexpected beat tdata=%h tlast=%b",
                                          o_m_axis_tdata, o_m_axis_tlast));
            end else begin
                want_key = pending_keys.pop_front();
                keys_checked++;
                if (got_key.code !== want_key.code)
                    report_mismatch($sformatf("key_code %h, expected %h (row %0d col %0d)",
                                              got_key.code, want_key.code,
                                              want_key.row, want_key.col));
                if (got_key.row !== want_key.row)
                    report_mismatch($sformatf("key_row %0d, expected %0d",
                                              got_key.row, want_key.row));
                if (got_key.col !== want_key.col)
                    report_mismatch($sformatf("key_col %0d, expected %0d",
                                              got_key.col, want_key.col));
                if (got_key.last !== want_key.last)
                    report_mismatch($sformatf("tlast %b, expected %b (row %0d col %0d)",
                                              got_key.last, want_key.last,
                                              want_key.row, want_key.col));
                if (o_m_axis_tdata[15:14] !== 2'b00)
                    report_mismatch($sformatf("tdata pad bits %b", o_m_axis_tdata[15:14]));
            end
        end
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            decode_tick(i_s_axis_tdata);
            ticks_taken++;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (i_s_axis_tvalid && !in_fire) begin
            i_s_axis_tvalid <= 1'b1;
        end else if (hold_off > 0) begin
            i_s_axis_tvalid <= 1'b0;
            hold_off <= hold_off - 1;
        end else if (scan_ticks.size() > 0) begin
            next_tick = scan_ticks.pop_front();
            i_s_axis_tvalid <= 1'b1;
            i_s_axis_tdata <= next_tick.levels;
            hold_off <= next_tick.gap;
        end else begin
            i_s_axis_tvalid <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            i_m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_m_axis_tready <= 1'b1;
            if ((cycle_count / 1500) % 4 != 0 && $urandom_range(0, 99) < 25)
                stall_left <= pick_gap();
        end
    end

    initial begin
        logic [63:0] held;
        logic [7:0]  lv;
        int unsigned c;
        int unsigned r;
        held = '0;

        // col 0..7 all pressed: plain, then shift, fn and symbol latch as rows pass
        for (int k = 0; k < 8; k++)
            queue_tick(8'h00);
        queue_tick(8'h5F);   // col 0: row 5 and 7 held, shift stays
        queue_tick(8'hFF);   // col 1: release
        queue_tick(8'h7F);   // col 2: fn held
        queue_tick(8'h00);   // col 3: every key still held, no new press
        queue_tick(8'h00);   // col 4: no new press
        queue_tick(8'hFF);   // col 5
        queue_tick(8'hFF);   // col 6
        queue_tick(8'hFF);   // col 7
        queue_tick(8'hFF);   // col 0: shift released
        queue_tick(8'h00);   // col 1: symbol over fn
        queue_tick(8'hFF);   // col 2: fn released
        queue_tick(8'hFF);   // col 3: symbol released
        queue_tick(8'hFF);   // col 4: all released, plain again
        queue_tick(8'h00);   // col 5

        c = scan_ticks.size() % MATRIX_COLS;
        for (int i = 0; i < RANDOM_TICKS; i++) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                for (int row = 0; row < MATRIX_ROWS; row++)
                    if ($urandom_range(0, 99) < 30)
                        held[row * 8 + c] = ~held[row * 8 + c];
            end else begin
                if (r < 90)
                    lv = 8'($urandom());
                else if (r < 95)
                    lv = 8'hFF;
                else
                    lv = 8'h00;
                for (int row = 0; row < MATRIX_ROWS; row++)
                    held[row * 8 + c] = ~lv[row];
            end
            for (int row = 0; row < MATRIX_ROWS; row++)
                lv[row] = ~held[row * 8 + c];
            queue_tick(lv);
            c = (c + 1) % MATRIX_COLS;
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        @(negedge i_clk);
        while (scan_ticks.size() > 0 || i_s_axis_tvalid)
            @(negedge i_clk);
        while (pending_keys.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_keys.size() != 0)
            report_mismatch($sformatf("%0d key beats never arrived", pending_keys.size()));

        $display("Scanned %0d ticks, checked %0d key beats", ticks_taken, keys_checked);
        $display("Keymaps hit: plain %0d, shift %0d, symbol %0d, fn %0d",
                 map_hits[int'(KM_PLAIN)], map_hits[int'(KM_SHIFT)],
                 map_hits[int'(KM_SYMBOL)], map_hits[int'(KM_FN)]);
        if (mismatch_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
`default_nettype wire
